>>> src/rlse_pkg.sv
// ----------------------------------------------------------------------------
// rlse_pkg
// Types and constants shared by the LED strip frame encoder and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package rlse_pkg;

  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 8;
  localparam int COUNT_W    = 9;
  localparam int COLOR_W    = 24;
  localparam int WORD_W     = 16;
  localparam int STRIP_W    = 9;
  localparam int DUTY_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int BIT_CNT_W  = 5;

  localparam int unsigned BITS_PER_PIXEL = 24;

  localparam logic [WORD_W-1:0] RESET_WORD = 16'h8000;

  localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = 5'd13;
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 5'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SHOW  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO  = 2'd2;

  // packed RGB in, GRB as stored and sent
  function automatic logic [COLOR_W-1:0] to_grb(input logic [COLOR_W-1:0] rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

`default_nettype wire

>>> src/rlse_if.sv
// ----------------------------------------------------------------------------
// rlse_if
// Valid/ready channels of the LED strip frame encoder: command, word, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlse_in_if;
  logic                              valid;
  logic                              ready;
  logic [rlse_pkg::CMD_W-1:0]        cmd;
  logic [rlse_pkg::INDEX_W-1:0]      pixel_index;
  logic [rlse_pkg::COUNT_W-1:0]      fill_count;
  logic [rlse_pkg::COLOR_W-1:0]      packed_color;

  modport source (output valid, cmd, pixel_index, fill_count, packed_color, input ready);
  modport sink   (input valid, cmd, pixel_index, fill_count, packed_color, output ready);
endinterface

interface rlse_out_if;
  logic                              valid;
  logic                              ready;
  logic [rlse_pkg::WORD_W-1:0]       pwm_word;
  logic                              run_end;
  logic                              frame_end;

  modport source (output valid, pwm_word, run_end, frame_end, input ready);
  modport sink   (input valid, pwm_word, run_end, frame_end, output ready);
endinterface

interface rlse_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rlse_pkg::CFG_IDX_W-1:0]    index;
  logic [rlse_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/rgb_led_strip_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_encoder_unit
// Pixel store plus serializer that turns each pixel into 24 PWM duty words.
// ----------------------------------------------------------------------------
// Set pixel: written in its accept cycle. Fill: after the accept, writes
// fill_count entries. Clear: after the accept, writes all MAX_LEDS entries,
// one entry per cycle. Show: address registered, store read, then the shift
// register loads with the first word; then one word per cycle while the sink
// takes them; 24 words, 26 on the last pixel. One shift register serializes
// the pixel. Reset: a clearing pass zeroes the store; config writes only.
`default_nettype none

module rgb_led_strip_frame_encoder_unit #(
  parameter int MAX_LEDS = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  rlse_in_if.sink     in_bus,
  rlse_out_if.source  out_bus,
  rlse_cfg_if.sink    cfg_bus
);

  localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LEN_W  = ($clog2(MAX_LEDS + 1) > 9) ? $clog2(MAX_LEDS + 1) : 9;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_LEDS - 1);
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_LEDS);
  localparam logic [rlse_pkg::BIT_CNT_W-1:0] LAST_BIT =
    rlse_pkg::BIT_CNT_W'(rlse_pkg::BITS_PER_PIXEL - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_READ,
    S_LOAD,
    S_EMIT,
    S_TAIL
  } state_t;

  state_t                          state_r;
  logic [rlse_pkg::STRIP_W-1:0]    strip_len_r;
  logic [rlse_pkg::DUTY_W-1:0]     duty_one_r;
  logic [rlse_pkg::DUTY_W-1:0]     duty_zero_r;
  logic [ADDR_W-1:0]               clr_addr_r;
  logic [LEN_W-1:0]                fill_addr_r;
  logic [LEN_W-1:0]                fill_end_r;
  logic [rlse_pkg::COLOR_W-1:0]    color_r;
  logic [ADDR_W-1:0]               cursor_r;
  logic [ADDR_W-1:0]               rd_addr_r;
  logic [rlse_pkg::COLOR_W-1:0]    rd_data_r;
  logic [rlse_pkg::COLOR_W-1:0]    shift_r;
  logic [rlse_pkg::BIT_CNT_W-1:0]  bit_cnt_r;
  logic                            last_r;
  logic                            tail2_r;
  logic                            out_valid_r;
  logic [rlse_pkg::WORD_W-1:0]     out_word_r;
  logic                            out_run_r;
  logic                            out_frame_r;

  logic [rlse_pkg::COLOR_W-1:0]    mem [MAX_LEDS];

  logic                            in_ready_c;
  logic                            in_acc_c;
  logic                            out_acc_c;
  rlse_pkg::cmd_t                  cmd_c;
  logic [LEN_W-1:0]                len_c;
  logic [LEN_W-1:0]                idx_ext_c;
  logic [LEN_W:0]                  fill_sum_c;
  logic [LEN_W-1:0]                cur_ext_c;
  logic [ADDR_W-1:0]               cur_eff_c;
  logic [LEN_W:0]                  cur_inc_c;
  logic                            show_last_c;
  logic                            we_c;
  logic [ADDR_W-1:0]               wa_c;
  logic [rlse_pkg::COLOR_W-1:0]    wd_c;
  logic [rlse_pkg::WORD_W-1:0]     duty_one_w;
  logic [rlse_pkg::WORD_W-1:0]     duty_zero_w;

  assign in_ready_c   = (state_r == S_IDLE);
  assign in_acc_c     = in_bus.valid && in_ready_c;
  assign out_acc_c    = out_valid_r && out_bus.ready;
  assign cmd_c        = rlse_pkg::cmd_t'(in_bus.cmd);

  assign in_bus.ready      = in_ready_c;
  assign cfg_bus.ready     = 1'b1;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.pwm_word  = out_word_r;
  assign out_bus.run_end   = out_run_r;
  assign out_bus.frame_end = out_frame_r;

  assign duty_one_w  = rlse_pkg::WORD_W'(duty_one_r);
  assign duty_zero_w = rlse_pkg::WORD_W'(duty_zero_r);

  // effective strip length, capped at the store depth
  assign len_c = (LEN_W'(strip_len_r) > MAX_LEN) ? MAX_LEN : LEN_W'(strip_len_r);

  assign idx_ext_c  = LEN_W'(in_bus.pixel_index);
  assign fill_sum_c = {1'b0, idx_ext_c} + (LEN_W + 1)'(in_bus.fill_count);

  // a cursor left past a shrunken strip restarts at pixel zero
  assign cur_ext_c   = LEN_W'(cursor_r);
  assign cur_eff_c   = (cur_ext_c >= len_c) ? '0 : cursor_r;
  assign cur_inc_c   = (LEN_W + 1)'(cur_eff_c) + 1'b1;
  assign show_last_c = (cur_inc_c >= {1'b0, len_c});

  always_comb begin
    we_c = 1'b0;
    wa_c = clr_addr_r;
    wd_c = '0;
    case (state_r)
      S_CLEAR: begin
        we_c = 1'b1;
      end
      S_FILL: begin
        we_c = 1'b1;
        wa_c = fill_addr_r[ADDR_W-1:0];
        wd_c = color_r;
      end
      S_IDLE: begin
        we_c = in_acc_c && (cmd_c == rlse_pkg::CMD_SET) && (idx_ext_c < len_c);
        wa_c = idx_ext_c[ADDR_W-1:0];
        wd_c = rlse_pkg::to_grb(in_bus.packed_color);
      end
      default: begin
        we_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_len_r <= '0;
      duty_one_r  <= rlse_pkg::DUTY_ONE_RST;
      duty_zero_r <= rlse_pkg::DUTY_ZERO_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        rlse_pkg::REG_STRIP_LEN: strip_len_r <= cfg_bus.data;
        rlse_pkg::REG_DUTY_ONE:  duty_one_r  <= cfg_bus.data[rlse_pkg::DUTY_W-1:0];
        rlse_pkg::REG_DUTY_ZERO: duty_zero_r <= cfg_bus.data[rlse_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == LAST_ADDR) begin
            clr_addr_r <= '0;
            state_r    <= S_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_acc_c) begin
            case (cmd_c)
              rlse_pkg::CMD_SET: ;
              rlse_pkg::CMD_FILL: begin
                if ((fill_sum_c <= {1'b0, len_c}) && (in_bus.fill_count != '0)) begin
                  fill_addr_r <= idx_ext_c;
                  fill_end_r  <= fill_sum_c[LEN_W-1:0];
                  color_r     <= rlse_pkg::to_grb(in_bus.packed_color);
                  state_r     <= S_FILL;
                end
              end
              rlse_pkg::CMD_CLEAR: begin
                clr_addr_r <= '0;
                state_r    <= S_CLEAR;
              end
              rlse_pkg::CMD_SHOW: begin
                if (len_c != '0) begin
                  rd_addr_r <= cur_eff_c;
                  last_r    <= show_last_c;
                  cursor_r  <= show_last_c ? '0 : cur_inc_c[ADDR_W-1:0];
                  state_r   <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end

        S_FILL: begin
          fill_addr_r <= fill_addr_r + 1'b1;
          if (fill_addr_r + 1'b1 == fill_end_r) begin
            state_r <= S_IDLE;
          end
        end

        S_READ: begin
          state_r <= S_LOAD;
        end

        S_LOAD: begin
          out_valid_r <= 1'b1;
          out_word_r  <= rd_data_r[rlse_pkg::COLOR_W-1] ? duty_one_w : duty_zero_w;
          out_run_r   <= 1'b0;
          out_frame_r <= 1'b0;
          shift_r     <= {rd_data_r[rlse_pkg::COLOR_W-2:0], 1'b0};
          bit_cnt_r   <= '0;
          state_r     <= S_EMIT;
        end

        S_EMIT: begin
          if (out_acc_c) begin
            if (bit_cnt_r == LAST_BIT) begin
              if (last_r) begin
                out_word_r  <= rlse_pkg::RESET_WORD;
                out_run_r   <= 1'b0;
                out_frame_r <= 1'b0;
                tail2_r     <= 1'b0;
                state_r     <= S_TAIL;
              end else begin
                out_valid_r <= 1'b0;
                state_r     <= S_IDLE;
              end
            end else begin
              out_word_r <= shift_r[rlse_pkg::COLOR_W-1] ? duty_one_w : duty_zero_w;
              // run ends on the final bit unless reset words follow
              out_run_r  <= (bit_cnt_r + 1'b1 == LAST_BIT) && !last_r;
              shift_r    <= {shift_r[rlse_pkg::COLOR_W-2:0], 1'b0};
              bit_cnt_r  <= bit_cnt_r + 1'b1;
            end
          end
        end

        S_TAIL: begin
          if (out_acc_c) begin
            if (tail2_r) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              out_run_r   <= 1'b1;
              out_frame_r <= 1'b1;
              tail2_r     <= 1'b1;
            end
          end
        end

        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  a_no_cmd_while_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready_c)
    else $error("command taken while a word is pending");

  a_frame_on_reset_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_r) |-> (out_run_r && out_word_r == rlse_pkg::RESET_WORD))
    else $error("frame end not on a closing reset word");

  a_first_word_duty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_word_r == duty_one_w || out_word_r == duty_zero_w))
    else $error("show run does not start with a duty word");

  a_no_write_during_show: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_TAIL || state_r == S_READ) |-> !we_c)
    else $error("store written during a show");

endmodule

`default_nettype wire
